// ----- rtl/csm_pkg.sv -----
// shared types, constants and item codes for the compressed-row sparse matvec
// no dependencies
package csm_pkg;

    localparam int VectorDepthDef = 1024;
    localparam int DataWidthDef   = 32;
    localparam int IndexWidth     = 10;
    localparam int FracBits       = 16;
    localparam int AccWidth       = 64;
    localparam int RowNumWidth    = 16;
    localparam int QueueDepth     = 8;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_BEGIN = 2'd1;
    localparam logic [1:0] KIND_NZ    = 2'd2;

    localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
    localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

    typedef struct packed {
        logic [1:0]         kind;
        logic [9:0]         index;
        logic signed [31:0] data;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]     row_sum;
        logic [RowNumWidth-1:0] row_number;
        logic                   saturated;
    } t_out_item;

    typedef struct packed {
        logic                   valid;
        logic                   is_begin;
        logic                   emit;
        logic [RowNumWidth-1:0] row_num;
    } t_mac_ctl;

endpackage

// ----- rtl/csm_vec_store.sv -----
// dense vector store: one write port, one read port with registered read data
// depends on csm_pkg
module csm_vec_store import csm_pkg::*; #(
    parameter int VECTOR_DEPTH = VectorDepthDef,
    parameter int DATA_WIDTH   = DataWidthDef,
    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [VECTOR_DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/csm_mac.sv -----
// multiply, saturating accumulate into the Q32.32 row sum, then round down
// and clip to the output format; depends on csm_pkg
module csm_mac import csm_pkg::*; #(
    parameter int DATA_WIDTH = DataWidthDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_mac_ctl                     i_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_data,
    input  logic signed [DATA_WIDTH-1:0] i_vec,
    output logic                         o_push,
    output t_out_item                    o_item
);

    logic signed [2*DATA_WIDTH-1:0] prod;
    logic signed [AccWidth-1:0]     n_s2_val;
    t_mac_ctl                       r_s2_ctl;
    logic signed [AccWidth-1:0]     r_s2_val;

    logic signed [AccWidth-1:0]     r_acc;
    logic signed [AccWidth-1:0]     sum;
    logic                           ovf;
    logic signed [AccWidth-1:0]     n_acc;

    logic                           r_s3_valid;
    logic signed [AccWidth-1:0]     r_s3_sum;
    logic [RowNumWidth-1:0]         r_s3_row;
    logic signed [AccWidth-1:0]     q;
    logic                           fits;
    logic signed [DATA_WIDTH-1:0]   clipped;

    // stage 2 operand: product, or the prior row value moved to Q32.32
    assign prod = i_data * i_vec;
    assign n_s2_val = i_ctl.is_begin ? (AccWidth'(i_data) <<< FracBits)
                                     : AccWidth'(prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else begin
            r_s2_ctl <= i_ctl;
        end
        r_s2_val <= n_s2_val;
    end

    // saturating add at the signed 64-bit limits
    assign sum = r_acc + r_s2_val;
    assign ovf = (r_acc[AccWidth-1] == r_s2_val[AccWidth-1]) &&
                 (sum[AccWidth-1] != r_acc[AccWidth-1]);

    always_comb begin
        priority if (r_s2_ctl.is_begin) begin
            n_acc = r_s2_val;
        end else if (ovf) begin
            n_acc = r_acc[AccWidth-1] ? AccMin : AccMax;
        end else begin
            n_acc = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_s3_valid <= 1'b0;
        end else begin
            if (r_s2_ctl.valid) begin
                r_acc <= r_s2_ctl.emit ? '0 : n_acc;
            end
            r_s3_valid <= r_s2_ctl.valid && r_s2_ctl.emit;
        end
        r_s3_sum <= n_acc;
        r_s3_row <= r_s2_ctl.row_num;
    end

    // arithmetic shift is truncation toward minus infinity
    assign q    = r_s3_sum >>> FracBits;
    assign fits = (&q[AccWidth-1:DATA_WIDTH-1]) || (~|q[AccWidth-1:DATA_WIDTH-1]);

    always_comb begin
        priority if (fits) begin
            clipped = q[DATA_WIDTH-1:0];
        end else if (q[AccWidth-1]) begin
            clipped = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            clipped = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    assign o_push            = r_s3_valid;
    assign o_item.row_sum    = 32'(clipped);
    assign o_item.row_number = r_s3_row;
    assign o_item.saturated  = !fits;

endmodule

// ----- rtl/csm_out_queue.sv -----
// small result queue between the accumulator and the output channel
// depends on csm_pkg
module csm_out_queue import csm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    input  logic      i_pop,
    output logic      o_valid,
    output t_out_item o_item
);

    localparam int PW = $clog2(QueueDepth);
    localparam int CW = $clog2(QueueDepth + 1);

    t_out_item     r_mem [QueueDepth];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(pop);
        end
    end

endmodule

// ----- rtl/csr_sparse_matvec.sv -----
// channel  | valid   | stall   | payload
// in       | i_valid | o_stall | i_item (t_in_item)
// out      | o_valid | i_stall | o_item (t_out_item)
//
// one item per cycle while o_stall is low; a row result passes s1, s2 and s3, then waits in the queue
// the vector store is read once per beat, its registered read sets the first stage
// o_stall rises only while eight row results are in flight or waiting unread
// reset (synchronous, active low) clears the accumulator, row count and queue
// vector store contents are not reset
module csr_sparse_matvec import csm_pkg::*; #(
    parameter int VECTOR_DEPTH = VectorDepthDef,
    parameter int DATA_WIDTH   = DataWidthDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int XW = (AW > IndexWidth) ? AW : IndexWidth;
    localparam int CW = $clog2(QueueDepth + 1);

    logic                         accept;
    logic                         emitting;
    logic                         in_range;
    logic [XW-1:0]                idx_x;
    logic [AW-1:0]                addr;
    logic signed [DATA_WIDTH-1:0] in_data;
    logic [DATA_WIDTH-1:0]        rd_data;
    logic signed [DATA_WIDTH-1:0] vec;

    logic [RowNumWidth-1:0]       r_row_cnt;
    logic [RowNumWidth-1:0]       n_row_cnt;
    t_mac_ctl                     r_s1_ctl;
    logic signed [DATA_WIDTH-1:0] r_s1_data;
    logic                         r_s1_oob;

    logic [CW-1:0]                r_credit;
    logic                         push;
    t_out_item                    push_item;
    logic                         out_take;

    assign accept   = i_valid && !o_stall;
    assign emitting = ((i_item.kind == KIND_BEGIN) || (i_item.kind == KIND_NZ)) && i_item.last;
    assign in_range = 32'(i_item.index) < 32'(VECTOR_DEPTH);
    assign idx_x    = XW'(i_item.index);
    assign addr     = idx_x[AW-1:0];
    assign in_data  = i_item.data[DATA_WIDTH-1:0];

    csm_vec_store #(
        .VECTOR_DEPTH (VECTOR_DEPTH),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (i_item.kind == KIND_LOAD) && in_range),
        .i_wr_addr (addr),
        .i_wr_data (in_data),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    // row number is fixed in beat order, so it is settled at the input
    always_comb begin
        n_row_cnt = r_row_cnt;
        if (accept) begin
            if (i_item.kind == KIND_LOAD) begin
                n_row_cnt = '0;
            end else if (emitting) begin
                n_row_cnt = r_row_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_s1_ctl  <= '0;
        end else begin
            r_row_cnt         <= n_row_cnt;
            r_s1_ctl.valid    <= accept &&
                                 ((i_item.kind == KIND_BEGIN) || (i_item.kind == KIND_NZ));
            r_s1_ctl.is_begin <= (i_item.kind == KIND_BEGIN);
            r_s1_ctl.emit     <= emitting;
            r_s1_ctl.row_num  <= n_row_cnt;
        end
        r_s1_data <= in_data;
        r_s1_oob  <= !in_range;
    end

    // columns past the store read as zero
    assign vec = r_s1_oob ? '0 : rd_data;

    csm_mac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_s1_ctl),
        .i_data  (r_s1_data),
        .i_vec   (vec),
        .o_push  (push),
        .o_item  (push_item)
    );

    csm_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    // credits cover rows in the pipeline plus rows in the queue
    assign out_take = o_valid && !i_stall;
    assign o_stall  = (r_credit == CW'(QueueDepth));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CW'(accept && emitting) - CW'(out_take);
        end
    end

endmodule

// ----- rtl/csm_checker.sv -----
// port-level checks for the sparse matvec top level, bound in below
// depends on csm_pkg
module csm_checker import csm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_item  i_item,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);

    // nothing left over from before reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output or stall active after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled output beat changed");

    // a finished row always shows on o_valid after s1, s2, s3
    a_row_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_item.last &&
        ((i_item.kind == KIND_BEGIN) || (i_item.kind == KIND_NZ))
        |-> ##4 o_valid)
        else $error("row result missing four cycles after last beat");

endmodule

bind csr_sparse_matvec csm_checker u_chk (.*);

// ----- dv/csm_row_checker.sv -----
// row result checker for the compressed-row sparse matvec: watches both channels,
// predicts each row result from the accepted input beats and compares it field by field
// depends on csm_pkg for the beat types and item codes
module csm_row_checker import csm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending
);

    logic signed [31:0]         vec_mem [VectorDepthDef];
    logic signed [AccWidth-1:0] acc_q32;
    logic [RowNumWidth-1:0]     rows_done;
    t_out_item                  row_sums_due [$];
    int                         errors = 0;

    // floor to Q16.16, clip to 32 bits, count the row and clear the accumulator
    function automatic void close_row();
        logic signed [47:0] floored;
        t_out_item          res;
        floored   = acc_q32[63:16];
        rows_done = rows_done + 1'b1;
        if (floored[47:31] != {17{floored[47]}}) begin
            res.row_sum   = floored[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            res.saturated = 1'b1;
        end else begin
            res.row_sum   = floored[31:0];
            res.saturated = 1'b0;
        end
        res.row_number = rows_done;
        row_sums_due.push_back(res);
        acc_q32 = '0;
    endfunction

    function automatic void step_row_model(input t_in_item beat);
        logic signed [63:0] vec_wide;
        logic signed [63:0] val_wide;
        logic signed [63:0] prod;
        logic [64:0]        sum_wide;
        case (beat.kind)
            KIND_LOAD: begin
                vec_mem[beat.index] = beat.data;
                rows_done           = '0;
            end
            KIND_BEGIN: begin
                acc_q32 = {{16{beat.data[31]}}, beat.data, 16'b0};
                if (beat.last) close_row();
            end
            KIND_NZ: begin
                vec_wide = {{32{vec_mem[beat.index][31]}}, vec_mem[beat.index]};
                val_wide = {{32{beat.data[31]}}, beat.data};
                prod     = vec_wide * val_wide;
                sum_wide = {acc_q32[63], acc_q32} + {prod[63], prod};
                // the 64-bit accumulator sticks at its limits
                if (sum_wide[64] != sum_wide[63]) begin
                    acc_q32 = sum_wide[64] ? AccMin : AccMax;
                end else begin
                    acc_q32 = sum_wide[63:0];
                end
                if (beat.last) close_row();
            end
            default: begin
                // spare kind leaves everything alone
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item due;
        if (!i_rst_n) begin
            acc_q32   = '0;
            rows_done = '0;
            row_sums_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (row_sums_due.size() == 0) begin
                    errors++;
                    $error("row result with none expected: row_sum %0d row_number %0d",
                           i_out_item.row_sum, i_out_item.row_number);
                end else begin
                    due = row_sums_due.pop_front();
                    if (i_out_item.row_sum !== due.row_sum) begin
                        errors++;
                        $error("row_sum: expected %0d, got %0d",
                               due.row_sum, i_out_item.row_sum);
                    end
                    if (i_out_item.row_number !== due.row_number) begin
                        errors++;
                        $error("row_number: expected %0d, got %0d",
                               due.row_number, i_out_item.row_number);
                    end
                    if (i_out_item.saturated !== due.saturated) begin
                        errors++;
                        $error("saturated: expected %0d, got %0d",
                               due.saturated, i_out_item.saturated);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) step_row_model(i_in_item);
        end
        o_errors  <= errors;
        o_pending <= row_sums_due.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// top of the sparse matvec testbench: clock, reset, beat stimulus and receiver stalls
// depends on csm_pkg, csr_sparse_matvec and csm_row_checker
module tb_top;
    import csm_pkg::*;

    localparam logic [1:0] KindSpare  = 2'd3;
    localparam int         QuietLimit = 2000;
    localparam int         HoldCycles = 300;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_item  = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    int         row_errors;
    int         rows_pending;
    bit         calm      = 1'b0;
    bit         want_hold = 1'b0;
    bit         col_loaded [VectorDepthDef];
    logic [9:0] loaded_cols [$];

    csr_sparse_matvec i_dut (
        .i_clk,
        .i_rst_n,
        .i_valid,
        .o_stall,
        .i_item,
        .o_valid,
        .i_stall,
        .o_item
    );

    csm_row_checker i_row_checker (
        .i_clk,
        .i_rst_n,
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_item   (i_item),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_item  (o_item),
        .o_errors    (row_errors),
        .o_pending   (rows_pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1: return $urandom_range(1) ? 32'sh0 : -32'sh1;
            2, 3, 4: return $urandom();
            // mostly within +-8.0 so sums stay in range
            default: return 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
        endcase
    endfunction

    // only columns already loaded may be read
    function automatic logic [9:0] pick_column();
        return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
    endfunction

    task automatic send_beat(input logic [1:0] kind, input logic [9:0] index,
                             input logic signed [31:0] data, input logic last);
        bit stalled;
        while (!calm && $urandom_range(99) < 12) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= '{kind: kind, index: index, data: data, last: last};
        // o_stall is settled by the falling edge
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
        end while (stalled);
        if (kind == KIND_LOAD && !col_loaded[index]) begin
            col_loaded[index] = 1'b1;
            loaded_cols.push_back(index);
        end
    endtask

    // receiver: random stalls, plus one long hold-off once asked for
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (want_hold && !hold_done) begin
                hold_left = HoldCycles;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < 12);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        int n_rand;
        int pick;
        int n_beats;
        bit empty_row;
        bit left_open;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extreme entries at both ends of the store, last set on a load
        send_beat(KIND_LOAD, 10'd0, 32'sh7FFF_FFFF, 1'b1);
        send_beat(KIND_LOAD, 10'h3FF, 32'sh8000_0000, 1'b0);
        send_beat(KIND_LOAD, 10'h155, -32'sh1, 1'b0);
        send_beat(KIND_LOAD, 10'h2AA, 32'sh0001_0000, 1'b0);
        // empty rows at both output limits
        send_beat(KIND_BEGIN, 10'd0, 32'sh7FFF_FFFF, 1'b1);
        send_beat(KIND_BEGIN, 10'h3FF, 32'sh8000_0000, 1'b1);
        // accumulator runs past its top, then past its bottom
        send_beat(KIND_BEGIN, 10'd0, 32'sh0, 1'b0);
        send_beat(KIND_NZ, 10'h3FF, 32'sh8000_0000, 1'b0);
        send_beat(KIND_NZ, 10'h3FF, 32'sh8000_0000, 1'b1);
        send_beat(KIND_BEGIN, 10'd0, 32'sh8000_0000, 1'b0);
        repeat (3) send_beat(KIND_NZ, 10'd0, 32'sh8000_0000, 1'b0);
        send_beat(KIND_NZ, 10'd0, 32'sh8000_0000, 1'b1);
        // nonzero with no begin, spare kind, then a tiny negative sum that floors
        send_beat(KIND_NZ, 10'h2AA, 32'sh0001_8000, 1'b1);
        send_beat(KindSpare, 10'h3FF, -32'sh1, 1'b1);
        send_beat(KIND_NZ, 10'h155, 32'sh1, 1'b1);
        // reload clears the row count
        send_beat(KIND_LOAD, 10'h2AA, 32'sh0002_0000, 1'b0);
        send_beat(KIND_BEGIN, 10'h155, 32'sh0001_0000, 1'b0);
        send_beat(KIND_NZ, 10'h2AA, 32'sh0000_8000, 1'b1);

        n_rand = 0;
        while (n_rand < 640) begin
            calm = (n_rand >= 250 && n_rand < 400);
            pick = $urandom_range(99);
            if (pick < 8) begin
                n_beats = $urandom_range(1, 6);
                repeat (n_beats) begin
                    send_beat(KIND_LOAD, 10'($urandom()), pick_value(), 1'($urandom()));
                end
                n_rand += n_beats;
            end else if (pick < 11) begin
                send_beat(KindSpare, 10'($urandom()), pick_value(), 1'($urandom()));
            end else if (pick < 16) begin
                send_beat(KIND_NZ, pick_column(), pick_value(), 1'($urandom()));
                n_rand++;
            end else begin
                // a proper row, now and then left open for the next begin to overwrite
                empty_row = ($urandom_range(99) < 15);
                send_beat(KIND_BEGIN, 10'($urandom()), pick_value(), empty_row);
                n_rand++;
                if (!empty_row) begin
                    n_beats   = $urandom_range(1, 6);
                    left_open = ($urandom_range(99) < 8);
                    for (int k = 1; k <= n_beats; k++) begin
                        send_beat(KIND_NZ, pick_column(), pick_value(),
                                  k == n_beats && !left_open);
                    end
                    n_rand += n_beats;
                end
            end
        end

        // a burst of empty rows that fills the block, with the long hold-off at the start
        calm = 1'b0;
        send_beat(KIND_LOAD, 10'h3FF, pick_value(), 1'b0);
        want_hold = 1'b1;
        repeat (40) send_beat(KIND_BEGIN, 10'($urandom()), pick_value(), 1'b1);
        i_valid <= 1'b0;

        do @(posedge i_clk); while (rows_pending != 0);
        repeat (20) @(posedge i_clk);
        if (row_errors == 0 && rows_pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
